FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line pair validator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, ignored while arst_n is low.
`define TLV_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tlv assertion failed");

// Implication checked on every rising clk edge, ignored while arst_n is low.
`define TLV_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tlv assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define TLV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tlv assertion failed");

`endif

FILE: hw/rtl/tlv_pkg.sv
// ----------------------------------------------------------------------------
// tlv_pkg
// Types, constants and column tables of the line pair validator.
// ----------------------------------------------------------------------------
package tlv_pkg;

	localparam int unsigned ColW = 7;

	localparam logic [ColW-1:0] LineLen  = 7'd69;
	localparam logic [ColW-1:0] SumCol   = 7'd68;
	localparam logic [ColW-1:0] CountMax = 7'd127;
	localparam logic [ColW-1:0] IdFirst  = 7'd2;
	localparam logic [ColW-1:0] IdLast   = 7'd6;

	localparam logic [7:0] ChSpace  = 8'h20;
	localparam logic [7:0] ChPeriod = 8'h2E;
	localparam logic [7:0] ChMinus  = 8'h2D;
	localparam logic [7:0] ChZero   = 8'h30;
	localparam logic [7:0] ChNine   = 8'h39;
	localparam logic [7:0] ChOne    = 8'h31;
	localparam logic [7:0] ChTwo    = 8'h32;

	localparam logic [4:0] SumMod = 5'd10;

	typedef enum logic [3:0] {
		VERDICT_OK     = 4'd0,
		VERDICT_EMPTY  = 4'd1,
		VERDICT_NUMBER = 4'd2,
		VERDICT_LENGTH = 4'd3,
		VERDICT_SPACES = 4'd4,
		VERDICT_PERIOD = 4'd5,
		VERDICT_ID     = 4'd6,
		VERDICT_SUM1   = 4'd7,
		VERDICT_SUM2   = 4'd8
	} verdict_t;

	// One accepted character request.
	typedef struct packed {
		logic [7:0] char_byte;
		logic       has_char;
		logic       end_of_line;
	} item_t;

	// Result of the line state update for one item.
	typedef struct packed {
		logic     valid;
		verdict_t verdict;
	} result_t;

	// Faults raised by single characters of the current line.
	typedef struct packed {
		logic num;
		logic spc;
		logic per;
		logic id;
		logic sum;
	} char_faults_t;

	// Faults of a closed line.
	typedef struct packed {
		logic empty;
		logic num;
		logic len;
		logic spc;
		logic per;
		logic sum;
	} line_faults_t;

	function automatic logic is_space_col(logic second, logic [ColW-1:0] col);
		if (second) begin
			return col inside {7'd1, 7'd7, 7'd16, 7'd25, 7'd33, 7'd42, 7'd51};
		end
		return col inside {7'd1, 7'd8, 7'd17, 7'd32, 7'd43, 7'd52, 7'd61, 7'd63};
	endfunction

	function automatic logic is_period_col(logic second, logic [ColW-1:0] col);
		if (second) begin
			return col inside {7'd11, 7'd20, 7'd37, 7'd46, 7'd54};
		end
		return col inside {7'd23, 7'd34};
	endfunction

endpackage

FILE: hw/rtl/tlv_interfaces.sv
// ----------------------------------------------------------------------------
// tlv channel interfaces
// Valid/ready channels for character input and verdict output.
// ----------------------------------------------------------------------------
interface tlv_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       has_char;
	logic       end_of_line;

	modport source (output valid, char_byte, has_char, end_of_line, input ready);
	modport sink   (input valid, char_byte, has_char, end_of_line, output ready);
endinterface

interface tlv_verdict_if;
	logic       valid;
	logic       ready;
	logic [3:0] verdict;
	logic       pair_valid;

	modport source (output valid, verdict, pair_valid, input ready);
	modport sink   (input valid, verdict, pair_valid, output ready);
endinterface

FILE: hw/rtl/tle_line_pair_validator.sv
// ----------------------------------------------------------------------------
// tle_line_pair_validator
// Format check of a pair of 69-character orbital element lines.
// ----------------------------------------------------------------------------
// Characters enter one request per clock. An item with end_of_line closes the
// current line (with or without a character on the same item); the first line
// closed is line 1, the next line 2, and when line 2 closes one verdict request
// leaves on verdict_out: the first failing check by priority (empty line, line
// numbers, length, spaces, periods, catalogue id, checksum 1, checksum 2), or
// zero with pair_valid high. An accepted item sits in the input register; when
// it steps without a stall, the column state updates from it and, on a line-2
// close, the verdict loads into the output register at that same edge. Sustained
// rate is one item per cycle; the input stalls only when a line-2 close meets a
// full output register whose sink is not ready. No configuration, no clearing
// pass after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tle_line_pair_validator (
	input logic          clk,
	input logic          arst_n,
	tlv_char_if.sink     char_in,
	tlv_verdict_if.source verdict_out
);

	logic              valid_s1;
	tlv_pkg::item_t    item_s1;
	logic              out_valid_q;
	tlv_pkg::verdict_t verdict_q;
	logic              stall;
	logic              step;
	tlv_pkg::result_t  result;
	logic              result_pending;
	logic              result_line2;
	logic              line2_q;

	// Hold the input stage when its verdict has nowhere to go.
	assign stall = valid_s1 && item_s1.end_of_line && result_pending && out_valid_q &&
		!verdict_out.ready;
	assign step  = valid_s1 && !stall;

	assign result_pending = result_line2;

	tlv_line_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (result)
	);

	assign char_in.ready = !stall;

	// Advance the input register whenever the stage is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.valid && !stall) begin
			item_s1.char_byte   <= char_in.char_byte;
			item_s1.has_char    <= char_in.has_char;
			item_s1.end_of_line <= char_in.end_of_line;
		end
	end

	// Output register: load a new verdict, drop the old one once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.valid) begin
			out_valid_q <= 1'b1;
		end else if (verdict_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			verdict_q <= result.verdict;
		end
	end

	assign verdict_out.valid      = out_valid_q;
	assign verdict_out.verdict    = verdict_q;
	assign verdict_out.pair_valid = (verdict_q == tlv_pkg::VERDICT_OK);

	// Line select mirrored for the stall decision: a close on line 2 yields a verdict.
	assign result_line2 = line2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line2_q <= 1'b0;
		end else if (step && item_s1.end_of_line) begin
			line2_q <= !line2_q;
		end
	end

	`TLV_ASSERT_IMP(a_stall_has_item, !char_in.ready, valid_s1)
	`TLV_ASSERT_IMP(a_no_overwrite, result.valid && out_valid_q, verdict_out.ready)
	`TLV_ASSERT_IMP(a_line_mirror, result.valid, line2_q)

endmodule

FILE: hw/rtl/tlv_line_state.sv
// ----------------------------------------------------------------------------
// tlv_line_state
// Per-line state: column count, checksum, catalogue id and fault flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlv_line_state (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  tlv_pkg::item_t   item,
	output tlv_pkg::result_t result
);

	logic                         line_select_q;
	logic [tlv_pkg::ColW-1:0]     column_count_q;
	logic [3:0]                   digit_sum_q;
	logic [7:0]                   id_chars_q [5];
	tlv_pkg::line_faults_t        first_line_faults_q;
	tlv_pkg::char_faults_t        current_faults_q;

	logic [tlv_pkg::ColW-1:0]     col;
	logic [tlv_pkg::ColW-1:0]     count_nxt;
	logic [3:0]                   sum_nxt;
	logic [4:0]                   sum_wide;
	logic [3:0]                   add;
	logic [2:0]                   id_idx;
	logic                         in_line;
	logic                         is_digit;
	logic                         in_id;
	tlv_pkg::char_faults_t        faults_nxt;
	tlv_pkg::line_faults_t        f_line;
	tlv_pkg::line_faults_t        f_any;
	tlv_pkg::verdict_t            verdict;

	assign col      = column_count_q;
	assign in_line  = item.has_char && (col < tlv_pkg::LineLen);
	assign is_digit = (item.char_byte >= tlv_pkg::ChZero) && (item.char_byte <= tlv_pkg::ChNine);
	assign in_id    = (col >= tlv_pkg::IdFirst) && (col <= tlv_pkg::IdLast);
	assign id_idx   = 3'(col - tlv_pkg::IdFirst);

	always_comb begin
		count_nxt = column_count_q;
		if (item.has_char && column_count_q != tlv_pkg::CountMax) begin
			count_nxt = column_count_q + 7'd1;
		end

		add = 4'd0;
		if (is_digit) begin
			add = item.char_byte[3:0];
		end else if (item.char_byte == tlv_pkg::ChMinus) begin
			add = 4'd1;
		end
		sum_wide = {1'b0, digit_sum_q} + {1'b0, add};
		if (sum_wide >= tlv_pkg::SumMod) begin
			sum_wide = sum_wide - tlv_pkg::SumMod;
		end

		sum_nxt    = digit_sum_q;
		faults_nxt = current_faults_q;
		if (in_line) begin
			if (col == 7'd0 && item.char_byte !=
					(line_select_q ? tlv_pkg::ChTwo : tlv_pkg::ChOne)) begin
				faults_nxt.num = 1'b1;
			end
			if (col == 7'd1 && item.char_byte != tlv_pkg::ChSpace) begin
				faults_nxt.num = 1'b1;
			end
			if (tlv_pkg::is_space_col(line_select_q, col) &&
					item.char_byte != tlv_pkg::ChSpace) begin
				faults_nxt.spc = 1'b1;
			end
			if (tlv_pkg::is_period_col(line_select_q, col) &&
					item.char_byte != tlv_pkg::ChPeriod) begin
				faults_nxt.per = 1'b1;
			end
			if (in_id && line_select_q && id_chars_q[id_idx] != item.char_byte) begin
				faults_nxt.id = 1'b1;
			end
			if (col < tlv_pkg::SumCol) begin
				sum_nxt = sum_wide[3:0];
			end else if (!is_digit || item.char_byte[3:0] != digit_sum_q) begin
				faults_nxt.sum = 1'b1;
			end
		end

		// Close-of-line summary, taken after the character on the same item.
		f_line.empty = (count_nxt == 7'd0);
		f_line.num   = faults_nxt.num || (count_nxt < 7'd2);
		f_line.len   = (count_nxt != tlv_pkg::LineLen);
		f_line.spc   = faults_nxt.spc;
		f_line.per   = faults_nxt.per;
		f_line.sum   = faults_nxt.sum;
		f_any        = f_line | first_line_faults_q;

		if (f_any.empty) begin
			verdict = tlv_pkg::VERDICT_EMPTY;
		end else if (f_any.num) begin
			verdict = tlv_pkg::VERDICT_NUMBER;
		end else if (f_any.len) begin
			verdict = tlv_pkg::VERDICT_LENGTH;
		end else if (f_any.spc) begin
			verdict = tlv_pkg::VERDICT_SPACES;
		end else if (f_any.per) begin
			verdict = tlv_pkg::VERDICT_PERIOD;
		end else if (faults_nxt.id) begin
			verdict = tlv_pkg::VERDICT_ID;
		end else if (first_line_faults_q.sum) begin
			verdict = tlv_pkg::VERDICT_SUM1;
		end else if (f_line.sum) begin
			verdict = tlv_pkg::VERDICT_SUM2;
		end else begin
			verdict = tlv_pkg::VERDICT_OK;
		end
	end

	assign result.valid   = step && item.end_of_line && line_select_q;
	assign result.verdict = verdict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_select_q       <= 1'b0;
			column_count_q      <= '0;
			digit_sum_q         <= '0;
			first_line_faults_q <= '0;
			current_faults_q    <= '0;
		end else if (step) begin
			if (item.end_of_line) begin
				column_count_q   <= '0;
				digit_sum_q      <= '0;
				current_faults_q <= '0;
				line_select_q    <= !line_select_q;
				if (!line_select_q) begin
					first_line_faults_q <= f_line;
				end
			end else begin
				column_count_q   <= count_nxt;
				digit_sum_q      <= sum_nxt;
				current_faults_q <= faults_nxt;
			end
		end
	end

	// Catalogue id store, written by line 1 only.
	always_ff @(posedge clk) begin
		if (step && in_line && in_id && !line_select_q) begin
			id_chars_q[id_idx] <= item.char_byte;
		end
	end

	`TLV_ASSERT(a_sum_range, digit_sum_q < 4'd10)
	`TLV_ASSERT_NEXT(a_eol_clears, step && item.end_of_line, column_count_q == '0 && digit_sum_q == '0)
	`TLV_ASSERT_NEXT(a_line_toggle, step && item.end_of_line, line_select_q != $past(line_select_q))
	`TLV_ASSERT_IMP(a_no_id_on_line1, !line_select_q, !current_faults_q.id)

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pair validator testbench
// Streams orbital element line pairs into the validator, one character request
// per handshake, and checks every verdict request against a cycle-free model of
// the column checks. A directed table of mostly flawed pairs comes first, then a
// short back-pressure phase, then random pairs mixed with raw character noise.
// Both sides idle at random, bar the pressure phase and one long full-rate stretch.
// ----------------------------------------------------------------------------
module testbench;

	// Ways to spoil a generated line; FLAW_NONE gives a well-formed line.
	typedef enum logic [3:0] {
		FLAW_NONE,
		FLAW_EMPTY,
		FLAW_ONE_CHAR,
		FLAW_NUMBER,
		FLAW_SHORT,
		FLAW_LONG,
		FLAW_OVERFLOW,
		FLAW_SPACE,
		FLAW_PERIOD,
		FLAW_ID,
		FLAW_SUM,
		FLAW_CHECK_CHAR
	} flaw_e;

	typedef enum logic [1:0] {
		COL_FREE,
		COL_SPACE,
		COL_PERIOD
	} col_kind_e;

	// One row of the directed table: flaw of each line, and the verdict where
	// it is plain from the flaw alone.
	typedef struct packed {
		flaw_e             first;
		flaw_e             second;
		logic              listed;
		tlv_pkg::verdict_t verdict;
	} pair_case_t;

	typedef struct packed {
		tlv_pkg::verdict_t verdict;
		logic              pair_valid;
	} verdict_req_t;

	// Verdict typed into the table, tagged with the index of the pair it ends.
	typedef struct {
		int unsigned       index;
		tlv_pkg::verdict_t verdict;
	} listed_verdict_t;

	localparam int unsigned RandomItems = 500;
	localparam int unsigned RandomPairs = 3;
	localparam int unsigned QuietLimit  = 3000;
	localparam int unsigned HoldCycles  = 300;
	localparam int unsigned DrainCycles = 8;

	pair_case_t directed_pairs [10] = '{
		'{FLAW_NONE,       FLAW_NONE,       1'b1, tlv_pkg::VERDICT_OK},
		'{FLAW_EMPTY,      FLAW_NONE,       1'b1, tlv_pkg::VERDICT_EMPTY},
		'{FLAW_ONE_CHAR,   FLAW_NONE,       1'b1, tlv_pkg::VERDICT_NUMBER},
		'{FLAW_OVERFLOW,   FLAW_NONE,       1'b1, tlv_pkg::VERDICT_LENGTH},
		'{FLAW_NONE,       FLAW_SPACE,      1'b1, tlv_pkg::VERDICT_SPACES},
		'{FLAW_PERIOD,     FLAW_NONE,       1'b1, tlv_pkg::VERDICT_PERIOD},
		'{FLAW_NONE,       FLAW_ID,         1'b1, tlv_pkg::VERDICT_ID},
		'{FLAW_CHECK_CHAR, FLAW_NONE,       1'b1, tlv_pkg::VERDICT_SUM1},
		'{FLAW_NONE,       FLAW_SUM,        1'b1, tlv_pkg::VERDICT_SUM2},
		'{FLAW_ID,         FLAW_SUM,        1'b0, tlv_pkg::VERDICT_OK}
	};

	logic clk;
	logic arst_n;

	tlv_char_if    char_if ();
	tlv_verdict_if verdict_if ();

	tle_line_pair_validator u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_in     (char_if),
		.verdict_out (verdict_if)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Shared controls: written by the stimulus process only.
	bit idle_enable;
	bit pressure_on;

	// Driver-side bookkeeping of the line structure actually sent.
	int unsigned items_sent;
	int unsigned closes_sent;
	int unsigned chars_in_line;
	bit          on_second_line;

	logic [7:0] line_chars [$];
	logic [7:0] pair_id [5];

	// Model state of the column checks.
	bit                    pred_line2;
	logic [6:0]            pred_col;
	logic [3:0]            pred_sum;
	logic [7:0]            pred_id [5];
	tlv_pkg::line_faults_t pred_l1_faults;
	tlv_pkg::char_faults_t pred_faults;

	verdict_req_t    pending_verdicts [$];
	listed_verdict_t listed_verdicts [$];
	int unsigned     verdicts_made;
	int unsigned     errors;

	initial begin
		pred_line2     = 1'b0;
		pred_col       = '0;
		pred_sum       = '0;
		pred_l1_faults = '0;
		pred_faults    = '0;
		foreach (pred_id[k]) pred_id[k] = '0;
		verdicts_made  = 0;
		errors         = 0;
	end

	// ------------------------------------------------------------------------
	// Column layout and character helpers
	// ------------------------------------------------------------------------

	// Fixed character class of a column; column 1 is a space on both lines.
	function automatic col_kind_e fixed_char(input bit second, input int col);
		if (second) begin
			case (col)
				1, 7, 16, 25, 33, 42, 51: return COL_SPACE;
				11, 20, 37, 46, 54:       return COL_PERIOD;
				default:                  return COL_FREE;
			endcase
		end
		case (col)
			1, 8, 17, 32, 43, 52, 61, 63: return COL_SPACE;
			23, 34:                       return COL_PERIOD;
			default:                      return COL_FREE;
		endcase
	endfunction

	function automatic bit is_digit(input logic [7:0] ch);
		return ch >= tlv_pkg::ChZero && ch <= tlv_pkg::ChNine;
	endfunction

	// Checksum weight: digits count their value, a minus counts one.
	function automatic int digit_value(input logic [7:0] ch);
		if (is_digit(ch)) return int'(ch - tlv_pkg::ChZero);
		if (ch == tlv_pkg::ChMinus) return 1;
		return 0;
	endfunction

	function automatic logic [7:0] other_byte(input logic [7:0] avoid);
		logic [7:0] b;
		b = 8'($urandom_range(255));
		return (b == avoid) ? ~avoid : b;
	endfunction

	// Free-column content: mostly digits, some minus signs, some raw bytes.
	function automatic logic [7:0] random_content();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 75) return tlv_pkg::ChZero + 8'($urandom_range(9));
		if (r < 88) return tlv_pkg::ChMinus;
		return 8'($urandom_range(255));
	endfunction

	// ------------------------------------------------------------------------
	// Model of the validator: advance the column state by one character
	// request and, when line 2 closes, give the verdict of the pair.
	// ------------------------------------------------------------------------
	task automatic advance_line_check(input logic [7:0] ch, input logic has,
			input logic eol, output bit made, output tlv_pkg::verdict_t v);
		logic [6:0]            col;
		col_kind_e             kind;
		tlv_pkg::line_faults_t lf;
		made = 1'b0;
		v    = tlv_pkg::VERDICT_OK;
		if (has) begin
			col = pred_col;
			// Saturate the column count; late characters only feed the length check.
			if (pred_col != tlv_pkg::CountMax) pred_col = pred_col + 7'd1;
			if (col < tlv_pkg::LineLen) begin
				kind = fixed_char(pred_line2, int'(col));
				if (col == 0 && ch != (pred_line2 ? tlv_pkg::ChTwo : tlv_pkg::ChOne))
					pred_faults.num = 1'b1;
				if (col == 1 && ch != tlv_pkg::ChSpace) pred_faults.num = 1'b1;
				if (kind == COL_SPACE && ch != tlv_pkg::ChSpace) pred_faults.spc = 1'b1;
				if (kind == COL_PERIOD && ch != tlv_pkg::ChPeriod) pred_faults.per = 1'b1;
				if (col >= tlv_pkg::IdFirst && col <= tlv_pkg::IdLast) begin
					// Line 1 records the catalogue digits, line 2 compares.
					if (!pred_line2) pred_id[col - tlv_pkg::IdFirst] = ch;
					else if (pred_id[col - tlv_pkg::IdFirst] != ch) pred_faults.id = 1'b1;
				end
				if (col < tlv_pkg::SumCol) begin
					pred_sum = 4'((int'(pred_sum) + digit_value(ch)) % 10);
				end else if (!is_digit(ch) ||
						(ch - tlv_pkg::ChZero) != {4'd0, pred_sum}) begin
					pred_faults.sum = 1'b1;
				end
			end
		end
		if (eol) begin
			lf.empty = (pred_col == 0);
			lf.num   = pred_faults.num || pred_col < 2;
			lf.len   = (pred_col != tlv_pkg::LineLen);
			lf.spc   = pred_faults.spc;
			lf.per   = pred_faults.per;
			lf.sum   = pred_faults.sum;
			if (!pred_line2) begin
				pred_l1_faults = lf;
				pred_line2     = 1'b1;
			end else begin
				// First failing check of the pair, by priority.
				if (pred_l1_faults.empty || lf.empty) v = tlv_pkg::VERDICT_EMPTY;
				else if (pred_l1_faults.num || lf.num) v = tlv_pkg::VERDICT_NUMBER;
				else if (pred_l1_faults.len || lf.len) v = tlv_pkg::VERDICT_LENGTH;
				else if (pred_l1_faults.spc || lf.spc) v = tlv_pkg::VERDICT_SPACES;
				else if (pred_l1_faults.per || lf.per) v = tlv_pkg::VERDICT_PERIOD;
				else if (pred_faults.id) v = tlv_pkg::VERDICT_ID;
				else if (pred_l1_faults.sum) v = tlv_pkg::VERDICT_SUM1;
				else if (lf.sum) v = tlv_pkg::VERDICT_SUM2;
				made       = 1'b1;
				pred_line2 = 1'b0;
			end
			pred_col    = '0;
			pred_sum    = '0;
			pred_faults = '0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Scoreboard: predict on each accepted character request, then match each
	// accepted verdict request against the oldest expectation. Both are done
	// in one process so that the order within a time step is fixed.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		tlv_pkg::verdict_t v;
		bit                made;
		verdict_req_t      want;
		if (arst_n) begin
			if (char_if.valid && char_if.ready) begin
				advance_line_check(char_if.char_byte, char_if.has_char,
					char_if.end_of_line, made, v);
				if (made) begin
					// A verdict typed into the directed table takes precedence.
					if (listed_verdicts.size() != 0 &&
							listed_verdicts[0].index == verdicts_made) begin
						v = listed_verdicts[0].verdict;
						listed_verdicts.delete(0);
					end
					pending_verdicts.push_back('{v, v == tlv_pkg::VERDICT_OK});
					verdicts_made++;
				end
			end
			if (verdict_if.valid && verdict_if.ready) begin
				if (pending_verdicts.size() == 0) begin
					$display("%0t: unexpected verdict %0d pair_valid %0d", $time,
						verdict_if.verdict, verdict_if.pair_valid);
					errors++;
				end else begin
					want = pending_verdicts.pop_front();
					if (verdict_if.verdict !== want.verdict) begin
						$display("%0t: verdict expected %0d actual %0d", $time,
							want.verdict, verdict_if.verdict);
						errors++;
					end
					if (verdict_if.pair_valid !== want.pair_valid) begin
						$display("%0t: pair_valid expected %0d actual %0d", $time,
							want.pair_valid, verdict_if.pair_valid);
						errors++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Verdict sink: accept at random while idling is on, at full rate
	// otherwise, and hold off for a long stretch when pressure starts.
	// ------------------------------------------------------------------------
	initial begin : verdict_sink
		int unsigned hold_left;
		bit          hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		verdict_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			// Arm the hold-off once per pressure phase.
			if (pressure_on && !hold_seen) begin
				hold_left = HoldCycles;
				hold_seen = 1'b1;
			end
			if (!pressure_on) hold_seen = 1'b0;
			if (hold_left != 0) begin
				hold_left--;
				verdict_if.ready <= 1'b0;
			end else if (idle_enable) begin
				verdict_if.ready <= ($urandom_range(99) >= 34);
			end else begin
				verdict_if.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run when no request moves on either side for too long.
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((char_if.valid && char_if.ready) || (verdict_if.valid && verdict_if.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Character source
	// ------------------------------------------------------------------------

	// Offer one character request and hold it until accepted; track the
	// line structure on the way.
	task automatic put_item(input logic [7:0] ch, input logic has, input logic eol);
		if (idle_enable) begin
			while ($urandom_range(99) < 34) begin
				char_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		char_if.valid       <= 1'b1;
		char_if.char_byte   <= ch;
		char_if.has_char    <= has;
		char_if.end_of_line <= eol;
		do @(posedge clk); while (!char_if.ready);
		if (has) chars_in_line++;
		if (has || eol) items_sent++;
		if (eol) begin
			if (on_second_line) closes_sent++;
			on_second_line = !on_second_line;
			chars_in_line  = 0;
		end
	endtask

	// Close whatever noise left open, so that the next pair starts on line 1.
	task automatic resync();
		if (chars_in_line != 0) put_item(8'($urandom_range(255)), 1'b0, 1'b1);
		if (on_second_line) put_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	// Fill line_chars with a well-formed line, then spoil it as asked.
	task automatic build_line(input bit second, input flaw_e flaw);
		int         c;
		int         cut;
		int         sum;
		logic [7:0] ch;
		line_chars.delete();
		for (c = 0; c < int'(tlv_pkg::LineLen); c++) begin
			case (fixed_char(second, c))
				COL_SPACE:  ch = tlv_pkg::ChSpace;
				COL_PERIOD: ch = tlv_pkg::ChPeriod;
				default: begin
					if (c == 0) ch = second ? tlv_pkg::ChTwo : tlv_pkg::ChOne;
					else if (c >= int'(tlv_pkg::IdFirst) && c <= int'(tlv_pkg::IdLast))
						ch = pair_id[c - tlv_pkg::IdFirst];
					else ch = random_content();
				end
			endcase
			line_chars.push_back(ch);
		end
		// Spoil fixed columns before the checksum is computed, so the checksum still holds.
		case (flaw)
			FLAW_NUMBER: begin
				if ($urandom_range(1) == 1) line_chars[0] = other_byte(line_chars[0]);
				else line_chars[1] = other_byte(tlv_pkg::ChSpace);
			end
			FLAW_SPACE: begin
				// Skip column 1, which also carries the line number check.
				do c = $urandom_range(2, 67); while (fixed_char(second, c) != COL_SPACE);
				line_chars[c] = other_byte(tlv_pkg::ChSpace);
			end
			FLAW_PERIOD: begin
				do c = $urandom_range(2, 67); while (fixed_char(second, c) != COL_PERIOD);
				line_chars[c] = other_byte(tlv_pkg::ChPeriod);
			end
			FLAW_ID: begin
				c = $urandom_range(tlv_pkg::IdFirst, tlv_pkg::IdLast);
				line_chars[c] = line_chars[c] ^ (8'h01 << $urandom_range(7));
			end
			default: ;
		endcase
		sum = 0;
		for (c = 0; c < int'(tlv_pkg::SumCol); c++)
			sum = (sum + digit_value(line_chars[c])) % 10;
		line_chars[tlv_pkg::SumCol] = tlv_pkg::ChZero + 8'(sum);
		case (flaw)
			FLAW_SUM: line_chars[tlv_pkg::SumCol] =
				tlv_pkg::ChZero + 8'((sum + $urandom_range(1, 9)) % 10);
			FLAW_CHECK_CHAR: begin
				do ch = 8'($urandom_range(255)); while (is_digit(ch));
				line_chars[tlv_pkg::SumCol] = ch;
			end
			FLAW_SHORT: begin
				cut = $urandom_range(2, 68);
				while (line_chars.size() > cut) line_chars.delete(line_chars.size() - 1);
			end
			FLAW_LONG: repeat ($urandom_range(1, 20)) line_chars.push_back(8'($urandom_range(255)));
			// Run the column count into saturation.
			FLAW_OVERFLOW: repeat ($urandom_range(60, 90))
				line_chars.push_back(8'($urandom_range(255)));
			FLAW_ONE_CHAR: while (line_chars.size() > 1) line_chars.delete(line_chars.size() - 1);
			FLAW_EMPTY: line_chars.delete();
			default: ;
		endcase
	endtask

	// Send line_chars, closing either on the last character or with a bare
	// line end; scatter a few ignored requests in between.
	task automatic send_line();
		bit bare;
		int n;
		n    = line_chars.size();
		bare = (n == 0) || ($urandom_range(1) == 1);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 3) put_item(8'($urandom_range(255)), 1'b0, 1'b0);
			put_item(line_chars[i], 1'b1, !bare && i == n - 1);
		end
		if (bare) put_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	task automatic send_pair(input flaw_e first, input flaw_e second, input bit listed,
			input tlv_pkg::verdict_t verdict);
		resync();
		// Catalogue digits, now and then raw bytes.
		foreach (pair_id[k]) begin
			pair_id[k] = ($urandom_range(19) == 0) ? 8'($urandom_range(255))
				: tlv_pkg::ChZero + 8'($urandom_range(9));
		end
		build_line(1'b0, first);
		send_line();
		if (listed) listed_verdicts.push_back('{closes_sent, verdict});
		build_line(1'b1, second);
		send_line();
	endtask

	function automatic flaw_e random_flaw();
		if ($urandom_range(99) < 60) return FLAW_NONE;
		return flaw_e'($urandom_range(FLAW_EMPTY, FLAW_CHECK_CHAR));
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int unsigned pairs_start;
		int unsigned r;
		items_sent     = 0;
		closes_sent    = 0;
		chars_in_line  = 0;
		on_second_line = 1'b0;
		idle_enable    = 1'b1;
		pressure_on    = 1'b0;
		arst_n              <= 1'b0;
		char_if.valid       <= 1'b0;
		char_if.char_byte   <= '0;
		char_if.has_char    <= 1'b0;
		char_if.end_of_line <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table; the first row is a clean pair, which fills
		// every catalogue entry before any line 2 compares against it.
		foreach (directed_pairs[i]) begin
			send_pair(directed_pairs[i].first, directed_pairs[i].second,
				directed_pairs[i].listed, directed_pairs[i].verdict);
		end

		// Pressure: stream empty pairs at full rate while the sink holds off,
		// so the output register fills and the input stalls.
		idle_enable = 1'b0;
		pressure_on = 1'b1;
		repeat (40) send_pair(FLAW_EMPTY, FLAW_EMPTY, 1'b1, tlv_pkg::VERDICT_EMPTY);
		pressure_on = 1'b0;
		idle_enable = 1'b1;
		// Pause the source until every verdict is out.
		char_if.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);

		// Random part: mostly well-formed pairs with random content and flaws,
		// the rest raw character noise; keep going until enough pairs closed.
		items_sent  = 0;
		pairs_start = closes_sent;
		while (items_sent < RandomItems || closes_sent - pairs_start < RandomPairs) begin
			// Run at full rate on both sides for a long stretch.
			idle_enable = !(items_sent >= RandomItems / 4 && items_sent < RandomItems * 3 / 4);
			r = $urandom_range(99);
			if (r < 85) begin
				send_pair(random_flaw(), random_flaw(), 1'b0, tlv_pkg::VERDICT_OK);
			end else begin
				repeat ($urandom_range(1, 30)) begin
					put_item(8'($urandom_range(255)), $urandom_range(99) < 85,
						$urandom_range(99) < 6);
				end
			end
		end
		char_if.valid <= 1'b0;

		// Drain: wait for every verdict, then a few more cycles for strays.
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
